>>> hdl/psh_pkg.sv
package psh_pkg;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 32;
	localparam int LEN_W       = 13;
	localparam int CNT_W       = 16;
	localparam int HASH_W      = 32;
	localparam int MIN_LEN_W   = 13;
	localparam int TCOUNT_W    = 3;
	localparam int IDX_W       = 2;

	localparam int DEFAULT_MAX_CHARS   = 8191;
	localparam int DEFAULT_MAX_TARGETS = 4;

	localparam logic [HASH_W-1:0]    FNV_BASIS        = 32'h811c9dc5;
	localparam logic [HASH_W-1:0]    FNV_PRIME        = 32'h01000193;
	localparam logic [MIN_LEN_W-1:0] MIN_LENGTH_RESET = 13'd10;
	localparam logic [CNT_W-1:0]     CNT_SAT          = 16'hFFFF;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_MIN_LENGTH   = 3'd0,
		REG_UNICODE_MODE = 3'd1,
		REG_TARGET_COUNT = 3'd2,
		REG_TARGET_HASH0 = 3'd3,
		REG_TARGET_HASH1 = 3'd4,
		REG_TARGET_HASH2 = 3'd5,
		REG_TARGET_HASH3 = 3'd6
	} cfg_reg_t;

	function automatic logic [HASH_W-1:0] fnv_step(input logic [HASH_W-1:0] h,
		input logic [7:0] c);
		logic [HASH_W-1:0] x;
		x = h ^ {24'd0, c};
		return HASH_W'(x * FNV_PRIME);
	endfunction

	function automatic logic is_printable(input logic [7:0] b, input logic uni);
		logic p;
		p = (b == 8'h09) || (b == 8'h0A) || (b == 8'h0D);
		p = p || ((b >= 8'h20) && (b <= 8'h7E));
		p = p || (uni && (b >= 8'hA0));
		return p;
	endfunction

endpackage

>>> hdl/psh_if.sv
interface psh_scan_if import psh_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       chunk_start;

	modport source (output valid, data_byte, chunk_start, input ready);
	modport sink (input valid, data_byte, chunk_start, output ready);
endinterface

interface psh_result_if import psh_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [HASH_W-1:0] string_hash;
	logic [LEN_W-1:0]  string_length;
	logic              hit;
	logic [IDX_W-1:0]  hit_index;

	modport source (output valid, string_hash, string_length, hit, hit_index, input ready);
	modport sink (input valid, string_hash, string_length, hit, hit_index, output ready);
endinterface

>>> hdl/printable_string_scan_hash.sv
// Printable string scanner: takes one memory byte per cycle, except while a
// string-ending byte waits on an untaken result, and reports each finished
// ASCII or UTF-16LE string of at least min_length characters with its FNV-1a
// 32 hash, capped length and a match against the target hashes. A byte is
// held in an input register, then the window, count and hash update plus the
// target compare feed the result register combinationally, at a rate set by
// the string state update loop. A byte that ends a string waits in the input
// register only while the prior result is untaken. Configuration must be
// written only while no bytes are in flight; the block does not enforce it.
module printable_string_scan_hash import psh_pkg::*; #(
	parameter int MAX_CHARS   = DEFAULT_MAX_CHARS,
	parameter int MAX_TARGETS = DEFAULT_MAX_TARGETS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	psh_scan_if.sink               scan,
	psh_result_if.source           result
);

	localparam logic [CNT_W-1:0]    MaxCharsC   = CNT_W'(MAX_CHARS);
	localparam logic [TCOUNT_W-1:0] MaxTargetsC = TCOUNT_W'(MAX_TARGETS);

	// configuration
	logic [MIN_LEN_W-1:0] min_length_q;
	logic                 unicode_mode_q;
	logic [TCOUNT_W-1:0]  target_count_q;
	logic [HASH_W-1:0]    target_hash_q [MAX_TARGETS];

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       chunk_s1;

	// string state
	logic [7:0]        last_byte_q;
	logic              last_printable_q;
	logic              older_printable_q;
	logic [CNT_W-1:0]  char_count_q;
	logic [HASH_W-1:0] running_hash_q;
	logic [HASH_W-1:0] hash_before_last_q;
	logic [HASH_W-1:0] last_byte_hash_q;

	// result register
	logic              res_valid_q;
	logic [HASH_W-1:0] res_hash_q;
	logic [LEN_W-1:0]  res_len_q;
	logic              res_hit_q;
	logic [IDX_W-1:0]  res_idx_q;

	// next state and result
	logic [CNT_W-1:0]    n_cc;
	logic [HASH_W-1:0]   n_rh, n_hbl;
	logic                emit;
	logic [CNT_W-1:0]    emit_len;
	logic [HASH_W-1:0]   emit_hash;
	logic [CNT_W-1:0]    cap_len;
	logic                hit;
	logic [IDX_W-1:0]    hit_idx;
	logic [TCOUNT_W-1:0] active_targets;
	logic                p_cur;
	logic                advance;
	logic                in_fire;

	always_comb begin
		logic [7:0]        e_lb;
		logic              e_lp, e_op;
		logic [CNT_W-1:0]  e_cc;
		logic [HASH_W-1:0] e_rh, e_hbl, e_lbh;
		logic [HASH_W-1:0] app_rh;
		logic [CNT_W-1:0]  app_cc;
		logic              ge_min, gt_min;

		if (chunk_s1) begin
			e_lb  = 8'd0;
			e_lp  = 1'b0;
			e_op  = 1'b0;
			e_cc  = '0;
			e_rh  = FNV_BASIS;
			e_hbl = FNV_BASIS;
			e_lbh = FNV_BASIS;
		end else begin
			e_lb  = last_byte_q;
			e_lp  = last_printable_q;
			e_op  = older_printable_q;
			e_cc  = char_count_q;
			e_rh  = running_hash_q;
			e_hbl = hash_before_last_q;
			e_lbh = last_byte_hash_q;
		end

		p_cur  = is_printable(byte_s1, unicode_mode_q);
		app_rh = (e_cc < MaxCharsC) ? fnv_step(e_rh, byte_s1) : e_rh;
		app_cc = (e_cc != CNT_SAT) ? e_cc + 1'b1 : e_cc;
		ge_min = e_cc >= CNT_W'(min_length_q);
		gt_min = e_cc > CNT_W'(min_length_q);

		n_cc      = e_cc;
		n_rh      = e_rh;
		n_hbl     = e_hbl;
		emit      = 1'b0;
		emit_len  = e_cc;
		emit_hash = e_rh;

		if (e_op && e_lp && p_cur) begin
			n_hbl = e_rh;
			n_rh  = app_rh;
			n_cc  = app_cc;
		end else if (e_op && e_lp) begin
			if (ge_min) begin
				emit  = 1'b1;
				n_cc  = '0;
				n_rh  = FNV_BASIS;
				n_hbl = FNV_BASIS;
			end else if (byte_s1 == 8'd0) begin
				// A zero after two printables may start a UTF-16LE string.
				n_cc  = CNT_W'(1);
				n_hbl = FNV_BASIS;
				n_rh  = e_lbh;
			end else begin
				n_cc  = '0;
				n_rh  = FNV_BASIS;
				n_hbl = FNV_BASIS;
			end
		end else if (e_op && p_cur) begin
			if (e_lb == 8'd0) begin
				n_hbl = e_rh;
				n_rh  = app_rh;
				n_cc  = app_cc;
			end
		end else if (e_op) begin
			emit  = ge_min;
			n_cc  = '0;
			n_rh  = FNV_BASIS;
			n_hbl = FNV_BASIS;
		end else if (e_lp && p_cur) begin
			if (gt_min) begin
				// The string ended one byte back; report it without that byte.
				emit      = 1'b1;
				emit_len  = e_cc - 1'b1;
				emit_hash = e_hbl;
				n_cc      = '0;
				n_rh      = FNV_BASIS;
				n_hbl     = FNV_BASIS;
			end else begin
				n_cc  = CNT_W'(2);
				n_hbl = e_lbh;
				n_rh  = fnv_step(e_lbh, byte_s1);
			end
		end else if (!e_lp && p_cur) begin
			n_hbl = e_rh;
			n_rh  = app_rh;
			n_cc  = app_cc;
		end
	end

	always_comb begin
		active_targets = (target_count_q > MaxTargetsC) ? MaxTargetsC : target_count_q;
		cap_len = (emit_len > MaxCharsC) ? MaxCharsC : emit_len;
		hit     = 1'b0;
		hit_idx = '0;
		// Scan downward so the lowest matching index wins.
		for (int i = MAX_TARGETS - 1; i >= 0; i--) begin
			if ((TCOUNT_W'(i) < active_targets) && (target_hash_q[i] == emit_hash)) begin
				hit     = 1'b1;
				hit_idx = IDX_W'(i);
			end
		end
	end

	assign advance     = valid_s1 && (!emit || !res_valid_q || result.ready);
	assign scan.ready  = !valid_s1 || advance;
	assign in_fire     = scan.valid && scan.ready;

	assign result.valid         = res_valid_q;
	assign result.string_hash   = res_hash_q;
	assign result.string_length = res_len_q;
	assign result.hit           = res_hit_q;
	assign result.hit_index     = res_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q   <= MIN_LENGTH_RESET;
			unicode_mode_q <= 1'b0;
			target_count_q <= '0;
			for (int i = 0; i < MAX_TARGETS; i++) target_hash_q[i] <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN_LENGTH:   min_length_q   <= cfg_data[MIN_LEN_W-1:0];
				REG_UNICODE_MODE: unicode_mode_q <= cfg_data[0];
				REG_TARGET_COUNT: target_count_q <= cfg_data[TCOUNT_W-1:0];
				default: begin
					for (int i = 0; i < MAX_TARGETS; i++) begin
						if (cfg_index == CFG_INDEX_W'(int'(REG_TARGET_HASH0) + i))
							target_hash_q[i] <= cfg_data[HASH_W-1:0];
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1  <= scan.data_byte;
			chunk_s1 <= scan.chunk_start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_byte_q        <= 8'd0;
			last_printable_q   <= 1'b0;
			older_printable_q  <= 1'b0;
			char_count_q       <= '0;
			running_hash_q     <= FNV_BASIS;
			hash_before_last_q <= FNV_BASIS;
			last_byte_hash_q   <= FNV_BASIS;
		end else if (advance) begin
			last_byte_q        <= byte_s1;
			older_printable_q  <= chunk_s1 ? 1'b0 : last_printable_q;
			last_printable_q   <= p_cur;
			char_count_q       <= n_cc;
			running_hash_q     <= n_rh;
			hash_before_last_q <= n_hbl;
			last_byte_hash_q   <= fnv_step(FNV_BASIS, byte_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			res_hash_q <= emit_hash;
			res_len_q  <= cap_len[LEN_W-1:0];
			res_hit_q  <= hit;
			res_idx_q  <= hit_idx;
		end
	end

endmodule
